[design/gef_pkg.sv]
package gef_pkg;

   localparam int PIX_BITS = 8;
   localparam int POS_BITS = 11;
   localparam int CSR_BITS = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_MODE  = 2'd2;

   localparam logic MODE_SOBEL   = 1'b0;
   localparam logic MODE_PREWITT = 1'b1;

   // gray = floor(sum * 683 / 2048), exact for sum < 2048
   localparam logic [10:0] DIV3_RECIP = 11'd683;
   localparam int          DIV3_SHIFT = 11;

   localparam logic [PIX_BITS-1:0] MAG_MAX = 8'd255;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel_red;
      logic [PIX_BITS-1:0] pixel_green;
      logic [PIX_BITS-1:0] pixel_blue;
   } pixel_type;

   typedef struct packed {
      logic [POS_BITS-1:0] center_column;
      logic [POS_BITS-1:0] center_row;
      logic [PIX_BITS-1:0] x_gradient_mag;
      logic [PIX_BITS-1:0] y_gradient_mag;
      logic                frame_done;
   } result_type;

   // taps[row*3 + col], row 0 is the oldest line, col 0 the leftmost column
   typedef struct packed {
      logic [POS_BITS-1:0]          center_column;
      logic [POS_BITS-1:0]          center_row;
      logic                         frame_done;
      logic [8:0][PIX_BITS-1:0]     taps;
   } window_type;

endpackage

[design/gef_channels.sv]
interface gef_req_if;
   import gef_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface gef_rsp_if;
   import gef_pkg::*;

   logic       valid;
   logic       ready;
   result_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[design/gef_front.sv]
module gef_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   gef_req_if.sink                           req_chan,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    image_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   image_height,
   output logic                              push_valid,
   input  logic                              push_ready,
   output gef_pkg::window_type               push_data
);
   import gef_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);
   localparam int SIZE_W   = $clog2(MAX_WIDTH+1);
   localparam int SIZE_H   = $clog2(MAX_HEIGHT+1);

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                col_last, row_last;
   logic                accept, a_fire;

   logic [9:0]          sum;
   logic [20:0]         prod;
   logic [PIX_BITS-1:0] gray;

   logic                valid_a_ff;
   logic [PIX_BITS-1:0] gray_a_ff;
   logic [COL_BITS-1:0] col_a_ff;
   logic [ROW_BITS-1:0] row_a_ff;
   logic                emit_a_ff;
   logic                done_a_ff;

   // each entry: {upper line, middle line}
   logic [2*PIX_BITS-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_BITS-1:0] line_rd_ff;
   logic [PIX_BITS-1:0]   up, mid;

   logic [2:0][1:0][PIX_BITS-1:0] taps_ff, taps_in;
   logic [2:0][PIX_BITS-1:0]      new_col;

   assign accept = req_chan.valid && req_chan.ready;
   assign a_fire = valid_a_ff && (!emit_a_ff || push_ready);
   assign req_chan.ready = !valid_a_ff || a_fire;

   assign sum  = {2'b00, req_chan.data.pixel_red} + {2'b00, req_chan.data.pixel_green}
               + {2'b00, req_chan.data.pixel_blue};
   assign prod = 21'(sum) * 21'(DIV3_RECIP);
   assign gray = prod[DIV3_SHIFT +: PIX_BITS];

   assign col_last = (SIZE_W'(col_ff) + SIZE_W'(1)) >= image_width;
   assign row_last = (SIZE_H'(row_ff) + SIZE_H'(1)) >= image_height;

   always_comb begin
      col_in = col_ff + COL_BITS'(1);
      row_in = row_ff;
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_ff + ROW_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         valid_a_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            valid_a_ff <= 1'b1;
         end else if (a_fire) begin
            valid_a_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gray_a_ff <= gray;
         col_a_ff  <= col_ff;
         row_a_ff  <= row_ff;
         emit_a_ff <= (col_ff >= COL_BITS'(2)) && (row_ff >= ROW_BITS'(2));
         done_a_ff <= col_last && row_last;
      end
   end

   assign up  = line_rd_ff[2*PIX_BITS-1:PIX_BITS];
   assign mid = line_rd_ff[PIX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[col_ff];
      end
      if (a_fire) begin
         line_mem[col_a_ff] <= {mid, gray_a_ff};
      end
   end

   assign new_col[0] = up;
   assign new_col[1] = mid;
   assign new_col[2] = gray_a_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         taps_in[i][0] = taps_ff[i][1];
         taps_in[i][1] = new_col[i];
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         taps_ff <= taps_in;
      end
   end

   always_comb begin
      push_data.center_column = POS_BITS'(col_a_ff - COL_BITS'(1));
      push_data.center_row    = POS_BITS'(row_a_ff - ROW_BITS'(1));
      push_data.frame_done    = done_a_ff;
      for (int i = 0; i < 3; i++) begin
         push_data.taps[i*3]     = taps_ff[i][0];
         push_data.taps[i*3 + 1] = taps_ff[i][1];
         push_data.taps[i*3 + 2] = new_col[i];
      end
   end

   assign push_valid = valid_a_ff && emit_a_ff;

endmodule

[design/gef_queue.sv]
module gef_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  gef_pkg::window_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output gef_pkg::window_type pop_data
);
   import gef_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH+1);

   window_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push_fire, pop_fire;

   assign push_ready = count_ff != CNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
   assign rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);

   always_comb begin
      case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      push_fire && !pop_fire |=> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("queue count missed a push");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers differ while empty");

endmodule

[design/gef_back.sv]
module gef_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                filter_mode,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  gef_pkg::window_type pop_data,
   gef_rsp_if.source           rsp_chan
);
   import gef_pkg::*;

   function automatic logic [PIX_BITS-1:0] sat_diff(input logic [9:0] a, input logic [9:0] b);
      logic [9:0] d;
      d = (a >= b) ? a - b : b - a;
      return (d > 10'(MAG_MAX)) ? MAG_MAX : d[PIX_BITS-1:0];
   endfunction

   logic [8:0][PIX_BITS-1:0] p;
   logic [3:0][8:0]          mw;
   logic [9:0]               xp, xn, yp, yn;
   logic                     load;
   logic                     rsp_valid_ff;
   result_type               result_ff, result_in;

   assign p = pop_data.taps;

   // center weight of each outer kernel row/column: 1 for Prewitt, 2 for Sobel
   always_comb begin
      mw[0] = (filter_mode == MODE_PREWITT) ? {1'b0, p[1]} : {p[1], 1'b0};
      mw[1] = (filter_mode == MODE_PREWITT) ? {1'b0, p[3]} : {p[3], 1'b0};
      mw[2] = (filter_mode == MODE_PREWITT) ? {1'b0, p[5]} : {p[5], 1'b0};
      mw[3] = (filter_mode == MODE_PREWITT) ? {1'b0, p[7]} : {p[7], 1'b0};
   end

   assign xp = 10'(p[2]) + 10'(mw[2]) + 10'(p[8]);
   assign xn = 10'(p[0]) + 10'(mw[1]) + 10'(p[6]);
   assign yp = 10'(p[6]) + 10'(mw[3]) + 10'(p[8]);
   assign yn = 10'(p[0]) + 10'(mw[0]) + 10'(p[2]);

   always_comb begin
      result_in.center_column  = pop_data.center_column;
      result_in.center_row     = pop_data.center_row;
      result_in.x_gradient_mag = sat_diff(xp, xn);
      result_in.y_gradient_mag = sat_diff(yp, yn);
      result_in.frame_done     = pop_data.frame_done;
   end

   assign pop_ready = !rsp_valid_ff || rsp_chan.ready;
   assign load      = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         rsp_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = result_ff;

endmodule

[design/gradient_edge_filter_rgb_unit.sv]
// 3x3 gradient edge filter over an RGB raster stream.
// req_chan carries one pixel per beat in raster order; each pixel becomes the
// gray level (r+g+b)/3. rsp_chan carries one beat per interior pixel: center
// column and row, |Gx| and |Gy| saturated at 255, and frame_done on the last
// interior pixel of the frame. Border pixels give no beat.
// csr_*: index 0 image width, 1 image height (both clamped to 3..MAX_*),
// 2 filter mode (0 Sobel, 1 Prewitt). Write only while the stream is idle.
// Throughput: one pixel per cycle while the queue has room, set by the line
// store, which takes one read at accept and one write-back of the previous
// pixel in the same cycle. The pixel that completes a window passes through the
// front stage register, the queue and the output register before its result
// beat is valid on rsp_chan.
// A 4-entry queue sits between the window front end and the kernel back end,
// so req_chan keeps taking pixels while rsp_chan is stalled until it fills;
// then req_chan.ready drops. Nothing is lost or repeated under stalls.
// Reset: position counters to zero, queue and output empty, registers to
// 640 x 480 or MAX_* if smaller, Sobel. Line store contents are not cleared;
// the first two rows and columns never reach a result.
module gradient_edge_filter_rgb_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   gef_req_if.sink                          req_chan,
   gef_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [gef_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gef_pkg::CSR_BITS-1:0]     csr_write_data
);
   import gef_pkg::*;

   localparam int SIZE_W = $clog2(MAX_WIDTH+1);
   localparam int SIZE_H = $clog2(MAX_HEIGHT+1);
   localparam int WIDTH_RESET  = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
   localparam int HEIGHT_RESET = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;

   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_H-1:0] height_ff, height_in;
   logic              mode_ff, mode_in;

   logic              push_valid, push_ready;
   window_type        push_data;
   logic              pop_valid, pop_ready;
   window_type        pop_data;

   always_comb begin
      if (32'(csr_write_data) < 32'd3) begin
         width_in = SIZE_W'(3);
      end else if (32'(csr_write_data) > 32'(MAX_WIDTH)) begin
         width_in = SIZE_W'(MAX_WIDTH);
      end else begin
         width_in = SIZE_W'(csr_write_data);
      end
      if (32'(csr_write_data) < 32'd3) begin
         height_in = SIZE_H'(3);
      end else if (32'(csr_write_data) > 32'(MAX_HEIGHT)) begin
         height_in = SIZE_H'(MAX_HEIGHT);
      end else begin
         height_in = SIZE_H'(csr_write_data);
      end
      mode_in = csr_write_data[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(WIDTH_RESET);
         height_ff <= SIZE_H'(HEIGHT_RESET);
         mode_ff   <= MODE_SOBEL;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= width_in;
            CSR_IMAGE_HEIGHT: height_ff <= height_in;
            CSR_FILTER_MODE:  mode_ff   <= mode_in;
            default: ;
         endcase
      end
   end

   gef_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .image_width  (width_ff),
      .image_height (height_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   gef_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   gef_back u_back (
      .clock       (clock),
      .reset       (reset),
      .filter_mode (mode_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_chan    (rsp_chan)
   );

endmodule
